### rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the cache tag model
// Field widths, register indexes and the per-cell control word.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int ADDR_W     = 32;
	localparam int CNT_W      = 32;
	localparam int LG_W       = 3;
	localparam int FILL_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAPPING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINES   = 2'd2;

	localparam logic [LG_W-1:0]  LINES_LOG2_RESET = 3'd6;
	localparam logic [CNT_W-1:0] CNT_MAX          = '1;

	// mapping mode codes
	localparam logic MAP_DIRECT = 1'b0;
	localparam logic MAP_FIFO   = 1'b1;

	// per-cell update command for one lookup
	typedef struct packed {
		logic load_new;   // write the lookup tag and set valid
		logic take_next;  // copy tag and valid from the next cell
	} cell_ctl_t;

endpackage

### rtl/chm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_req_if: lookup request channel
// Valid/ready channel that carries one access address and its kind.
// ----------------------------------------------------------------------------
interface chm_req_if
	import chm_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;
	logic              access_kind;

	modport source (output valid, output address, output access_kind, input ready);
	modport sink   (input valid, input address, input access_kind, output ready);
endinterface

### rtl/chm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_rsp_if: lookup result channel
// Valid/ready channel that carries hit/miss and the running counts.
// ----------------------------------------------------------------------------
interface chm_rsp_if
	import chm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [CNT_W-1:0] accesses_total;
	logic [CNT_W-1:0] hits_total;

	modport source (output valid, output hit, output accesses_total, output hits_total,
		input ready);
	modport sink   (input valid, input hit, input accesses_total, input hits_total,
		output ready);
endinterface

### rtl/chm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_cell: one tag line of the cell row
// Holds a tag and its valid bit, compares against the lookup key, and
// loads either the key or its right-hand neighbor's contents.
// ----------------------------------------------------------------------------
module chm_cell
	import chm_pkg::*;
#(
	parameter int TAG_W = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flush,
	input  cell_ctl_t        ctl,
	input  logic [TAG_W-1:0] key,
	input  logic [TAG_W-1:0] next_tag,
	input  logic             next_valid,
	output logic [TAG_W-1:0] tag,
	output logic             valid,
	output logic             match
);

	logic [TAG_W-1:0] tag_q;
	logic             valid_q;

	// valid bit: clear on flush, shift or set on update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flush) begin
			valid_q <= 1'b0;
		end else if (ctl.take_next) begin
			valid_q <= next_valid;
		end else if (ctl.load_new) begin
			valid_q <= 1'b1;
		end
	end

	// tag payload
	always_ff @(posedge clk) begin
		if (ctl.take_next) begin
			tag_q <= next_tag;
		end else if (ctl.load_new) begin
			tag_q <= key;
		end
	end

	assign tag   = tag_q;
	assign valid = valid_q;
	assign match = valid_q && (tag_q == key);

endmodule

### rtl/cache_hit_model_dm_fa_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_hit_model_dm_fa_fifo_top: cache tag model, direct mapped or FIFO
// Usage:
//   req carries a byte address and an access kind (0 fetch, 1 data); rsp
//   returns hit/miss with saturating access and hit counts that include
//   the current item. The cfg port writes mapping mode, split mode and
//   log2 of the lines in use; a write that changes a value invalidates
//   every line and clears both fill levels, counts are kept. Write the
//   configuration only while no item is in flight.
//   An accepted item waits in the lookup stage; its result is then held in
//   the output register. Throughput: one item per cycle while rsp.ready is
//   high; every cell of the tag row compares its line in the same cycle and
//   updates at the same edge, so each item sees the row its predecessor left.
//   If the receiver stalls, the result holds in the output register, one
//   more item waits in the lookup stage, and then req.ready drops.
//   Reset: all lines invalid, fill levels and counts zero, direct mapped,
//   unified, 64 lines. No clearing pass is needed.
// ----------------------------------------------------------------------------
module cache_hit_model_dm_fa_fifo_top
	import chm_pkg::*;
#(
	parameter int MAX_LINES        = 64,
	parameter int LINE_OFFSET_BITS = 6,
	parameter int ADDRESS_BITS     = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	chm_req_if.sink               req,
	chm_rsp_if.source             rsp
);

	localparam int TAG_W     = ADDRESS_BITS - LINE_OFFSET_BITS;
	localparam int LN_W      = $clog2(MAX_LINES + 1);
	localparam int POS_W     = ((LN_W > FILL_W) ? LN_W : FILL_W) + 1;
	localparam int LG_CAP_I  = (($clog2(MAX_LINES + 1) - 1) > 7) ? 7
		: ($clog2(MAX_LINES + 1) - 1);
	localparam logic [LG_W-1:0] LG_CAP = LG_W'(LG_CAP_I);

	// configuration registers
	logic            mapping_q;
	logic            split_q;
	logic [LG_W-1:0] lines_q;
	logic            flush;

	// lookup stage and result
	logic                  valid_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic                  kind_s1;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [CNT_W-1:0]      acc_q;
	logic [CNT_W-1:0]      hits_q;
	logic [FILL_W-1:0]     fill_q [2];

	logic                  adv;
	logic                  proc;

	// derived lookup values
	logic [ADDRESS_BITS-1:0] addr_eff;
	logic [LG_W-1:0]         lg_eff;
	logic [LG_W-1:0]         rlog2;
	logic                    half;
	logic [POS_W-1:0]        size;
	logic [POS_W-1:0]        base;
	logic [POS_W-1:0]        fill_cur;
	logic [POS_W-1:0]        fill_c;
	logic [POS_W-1:0]        dm_idx;
	logic                    full;
	logic [TAG_W-1:0]        key;
	logic                    hit;

	// cell row signals
	logic [TAG_W-1:0] tag_vec   [MAX_LINES];
	logic             valid_vec [MAX_LINES];
	logic [MAX_LINES-1:0] hit_vec;
	cell_ctl_t        ctl_vec   [MAX_LINES];

	// detect a changed configuration value
	always_comb begin
		flush = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				CFG_MAPPING: flush = (cfg_data[0] != mapping_q);
				CFG_SPLIT:   flush = (cfg_data[0] != split_q);
				CFG_LINES:   flush = (cfg_data != lines_q);
				default:     flush = 1'b0;
			endcase
		end
	end

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapping_q <= MAP_DIRECT;
			split_q   <= 1'b0;
			lines_q   <= LINES_LOG2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAPPING: mapping_q <= cfg_data[0];
				CFG_SPLIT:   split_q   <= cfg_data[0];
				CFG_LINES:   lines_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// handshake: advance when the output register is free or being taken
	assign adv       = !out_valid_q || rsp.ready;
	assign proc      = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;

	// hold the item waiting for lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			addr_s1 <= req.address;
			kind_s1 <= req.access_kind;
		end
	end

	// region geometry
	assign addr_eff = ADDRESS_BITS'(addr_s1);

	always_comb begin
		lg_eff = lines_q;
		if (lg_eff == '0) begin
			lg_eff = LG_W'(1);
		end
		if (lg_eff > LG_CAP) begin
			lg_eff = LG_CAP;
		end
	end

	assign rlog2    = split_q ? (lg_eff - LG_W'(1)) : lg_eff;
	assign half     = split_q & kind_s1;
	assign size     = POS_W'(1) << rlog2;
	assign base     = half ? size : '0;
	assign fill_cur = POS_W'(fill_q[half]);
	assign fill_c   = (fill_cur > size) ? size : fill_cur;
	assign full     = (fill_c == size);
	assign dm_idx   = base + (POS_W'(addr_eff >> LINE_OFFSET_BITS) & (size - POS_W'(1)));
	assign key      = (mapping_q == MAP_FIFO) ? TAG_W'(addr_eff >> LINE_OFFSET_BITS)
		: TAG_W'(addr_eff >> (LINE_OFFSET_BITS + int'(rlog2)));

	// row of tag cells
	for (genvar k = 0; k < MAX_LINES; k++) begin : g_cell
		localparam logic [POS_W-1:0] KK = POS_W'(k);
		logic [POS_W-1:0] rel;
		logic             in_reg;
		logic             dm_sel;
		logic             fa_search;
		logic             match;
		logic [TAG_W-1:0] next_tag;
		logic             next_valid;

		assign rel       = KK - base;
		assign in_reg    = (KK >= base) && (KK < base + size);
		assign dm_sel    = (KK == dm_idx);
		assign fa_search = in_reg && (rel < fill_c);
		assign hit_vec[k] = match && ((mapping_q == MAP_FIFO) ? fa_search : dm_sel);

		// decide this cell's update on a miss
		always_comb begin
			ctl_vec[k] = '0;
			if (proc && !hit) begin
				if (mapping_q == MAP_FIFO) begin
					if (full) begin
						ctl_vec[k].take_next = in_reg && (rel < size - POS_W'(1));
						ctl_vec[k].load_new  = in_reg && (rel == size - POS_W'(1));
					end else begin
						ctl_vec[k].load_new = in_reg && (rel == fill_c);
					end
				end else begin
					ctl_vec[k].load_new = dm_sel;
				end
			end
		end

		if (k < MAX_LINES - 1) begin : g_mid
			assign next_tag   = tag_vec[k+1];
			assign next_valid = valid_vec[k+1];
		end else begin : g_last
			assign next_tag   = '0;
			assign next_valid = 1'b0;
		end

		chm_cell #(
			.TAG_W (TAG_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.flush      (flush),
			.ctl        (ctl_vec[k]),
			.key        (key),
			.next_tag   (next_tag),
			.next_valid (next_valid),
			.tag        (tag_vec[k]),
			.valid      (valid_vec[k]),
			.match      (match)
		);
	end

	assign hit = |hit_vec;

	// FIFO fill levels, one per half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else if (flush) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else if (proc && !hit && (mapping_q == MAP_FIFO)) begin
			fill_q[half] <= full ? FILL_W'(size) : FILL_W'(fill_c + POS_W'(1));
		end
	end

	// result register and saturating counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			hits_q      <= '0;
		end else begin
			if (proc) begin
				out_valid_q <= 1'b1;
				if (acc_q != CNT_MAX) begin
					acc_q <= acc_q + CNT_W'(1);
				end
				if (hit && (hits_q != CNT_MAX)) begin
					hits_q <= hits_q + CNT_W'(1);
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			hit_q <= hit;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.hit            = hit_q;
	assign rsp.accesses_total = acc_q;
	assign rsp.hits_total     = hits_q;

endmodule

### rtl/chm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker: port-level checks of the cache tag model
// Watches the result channel; bound to the top level below.
// ----------------------------------------------------------------------------
module chm_checker
	import chm_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             hit,
	input logic [CNT_W-1:0] accesses_total,
	input logic [CNT_W-1:0] hits_total
);

	// a shown result always counts at least its own access
	a_acc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (accesses_total != '0))
		else $error("result shown with zero access count");

	// hits never outrun accesses
	a_hits_le_acc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (hits_total <= accesses_total))
		else $error("hit count exceeds access count");

	// a hit result has been counted
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && hit) |-> (hits_total != '0))
		else $error("hit reported with zero hit count");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(hit) && $stable(accesses_total) && $stable(hits_total)))
		else $error("stalled result changed");

endmodule

bind cache_hit_model_dm_fa_fifo_top chm_checker u_chm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.hit            (rsp.hit),
	.accesses_total (rsp.accesses_total),
	.hits_total     (rsp.hits_total)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cache tag model
// Drives byte addresses through the lookup channel and predicts hit/miss and
// the saturating access and hit counts with an in-bench tag row, covering
// direct mapped and FIFO modes, unified and split halves, and line counts
// from two to the maximum. Results are checked in order against a queue.
// ----------------------------------------------------------------------------
module tb_top;
	import chm_pkg::*;

	localparam int LINE_CNT    = 64;
	localparam int OFFSET_BITS = 6;
	localparam int TAG_W       = ADDR_W - OFFSET_BITS;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic             hit;
		logic [CNT_W-1:0] accesses;
		logic [CNT_W-1:0] hits;
	} lookup_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	chm_req_if req_ch ();
	chm_rsp_if rsp_ch ();

	cache_hit_model_dm_fa_fifo_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predicted tag row, configuration and counters
	logic [TAG_W-1:0]  tag_mem [LINE_CNT];
	logic              line_vld [LINE_CNT];
	logic [FILL_W-1:0] fill_cnt [2];
	logic              map_mode;
	logic              split_on;
	logic [LG_W-1:0]   lines_lg;
	logic [CNT_W-1:0]  acc_count;
	logic [CNT_W-1:0]  hit_count;

	lookup_result_t pending_q [$];
	int             err_count = 0;
	int             send_idle_pct = 0;
	int             stall_pct = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// drop all lines and both fill levels
	function automatic void invalidate_lines();
		for (int i = 0; i < LINE_CNT; i++) line_vld[i] = 1'b0;
		fill_cnt[0] = '0;
		fill_cnt[1] = '0;
	endfunction

	// mirror one register write; a changed value flushes the row
	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_MAPPING: begin
				if (data[0] != map_mode) begin
					map_mode = data[0];
					invalidate_lines();
				end
			end
			CFG_SPLIT: begin
				if (data[0] != split_on) begin
					split_on = data[0];
					invalidate_lines();
				end
			end
			CFG_LINES: begin
				if (data != lines_lg) begin
					lines_lg = data;
					invalidate_lines();
				end
			end
			default: ;
		endcase
	endfunction

	// look one address up in the predicted row and update it
	function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr,
		input logic kind);
		lookup_result_t   res;
		int unsigned      lg, rlog2, base, size, idx, fill, half;
		logic [TAG_W-1:0] tag;
		logic             hit;
		lg = 32'(lines_lg);
		if (lg < 1) lg = 1;
		while (lg > 1 && (1 << lg) > LINE_CNT) lg--;
		rlog2 = lg;
		base  = 0;
		half  = 0;
		if (split_on) begin
			rlog2 = lg - 1;
			half  = 32'(kind);
			base  = kind ? (1 << rlog2) : 0;
		end
		size = 1 << rlog2;
		hit  = 1'b0;
		if (map_mode == MAP_FIFO) begin
			tag  = TAG_W'(addr >> OFFSET_BITS);
			fill = 32'(fill_cnt[half]);
			if (fill > size) fill = size;
			for (int i = 0; i < fill; i++)
				if (line_vld[base + i] && tag_mem[base + i] == tag) hit = 1'b1;
			if (!hit) begin
				// full region: shift out the oldest tag
				if (fill == size) begin
					for (int i = 0; i + 1 < size; i++) begin
						tag_mem[base + i]  = tag_mem[base + i + 1];
						line_vld[base + i] = line_vld[base + i + 1];
					end
					fill = size - 1;
				end
				tag_mem[base + fill]  = tag;
				line_vld[base + fill] = 1'b1;
				fill_cnt[half]        = FILL_W'(fill + 1);
			end
		end else begin
			idx = base + ((addr >> OFFSET_BITS) & (size - 1));
			tag = TAG_W'(addr >> (OFFSET_BITS + rlog2));
			hit = line_vld[idx] && tag_mem[idx] == tag;
			if (!hit) begin
				tag_mem[idx]  = tag;
				line_vld[idx] = 1'b1;
			end
		end
		if (acc_count != CNT_MAX) acc_count++;
		if (hit && hit_count != CNT_MAX) hit_count++;
		res.hit      = hit;
		res.accesses = acc_count;
		res.hits     = hit_count;
		return res;
	endfunction

	// receiver back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		lookup_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result: hit %0b accesses %0h hits %0h", $time,
					rsp_ch.hit, rsp_ch.accesses_total, rsp_ch.hits_total);
				err_count++;
			end else begin
				exp_r = pending_q.pop_front();
				if (rsp_ch.hit !== exp_r.hit) begin
					$display("%0t: hit mismatch: expected %0b, actual %0b", $time,
						exp_r.hit, rsp_ch.hit);
					err_count++;
				end
				if (rsp_ch.accesses_total !== exp_r.accesses) begin
					$display("%0t: accesses_total mismatch: expected %0h, actual %0h",
						$time, exp_r.accesses, rsp_ch.accesses_total);
					err_count++;
				end
				if (rsp_ch.hits_total !== exp_r.hits) begin
					$display("%0t: hits_total mismatch: expected %0h, actual %0h",
						$time, exp_r.hits, rsp_ch.hits_total);
					err_count++;
				end
			end
		end
	end

	// send one item, holding valid until it is taken
	task automatic send_item(input logic [ADDR_W-1:0] addr, input logic kind);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.address     <= addr;
		req_ch.access_kind <= kind;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_q.push_back(predict_lookup(addr, kind));
	endtask

	// lower valid and hold until every result is back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// one register write, block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_cfg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 85; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 85; end
			default: begin send_idle_pct = 14; stall_pct = 14; end
		endcase
	endtask

	// reset config: unified, direct mapped, 64 lines; extremes and conflicts
	task automatic test_direct_mapped();
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_003F, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'hFFFF_FFC0, 1'b1);
		send_item(32'h0000_1000, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0FC0, 1'b1);
		wait_idle();
	endtask

	// two-line FIFO: fill, hit, evict oldest; then one line per half
	task automatic test_fifo_split();
		write_reg(CFG_MAPPING, {2'b00, MAP_FIFO});
		write_reg(CFG_LINES, 3'd1);
		send_item(32'h0000_0100, 1'b0);
		send_item(32'h0000_0200, 1'b1);
		send_item(32'h0000_0110, 1'b0);
		send_item(32'h0000_0300, 1'b0);
		send_item(32'h0000_0100, 1'b1);
		send_item(32'h0000_0300, 1'b0);
		wait_idle();
		write_reg(CFG_SPLIT, 3'd1);
		send_item(32'h0000_0100, 1'b0);
		send_item(32'h0000_0100, 1'b1);
		send_item(32'h0000_0100, 1'b0);
		send_item(32'h0000_0200, 1'b1);
		send_item(32'h0000_0100, 1'b1);
		send_item(32'h0000_0100, 1'b0);
		wait_idle();
	endtask

	// out-of-range line counts, same-value write, unknown index, upper data bits
	task automatic test_config_edges();
		write_reg(CFG_LINES, 3'd0);
		send_item(32'h8000_0040, 1'b1);
		wait_idle();
		write_reg(CFG_LINES, 3'd0);
		write_reg(CFG_UNUSED, 3'd7);
		send_item(32'h8000_0040, 1'b1);
		wait_idle();
		write_reg(CFG_LINES, 3'd7);
		write_reg(CFG_MAPPING, {2'b11, MAP_DIRECT});
		write_reg(CFG_SPLIT, 3'b111);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b1);
		send_item(32'h5555_5540, 1'b0);
		wait_idle();
	endtask

	// random traffic over several settings and idling mixes
	task automatic test_random_traffic();
		logic [CFG_DATA_W-1:0] phase_cfg [8][3];
		logic [TAG_W-1:0]      line_pool [16];
		logic [TAG_W-7:0]      tag_base [4];
		logic [ADDR_W-1:0]     addr;
		int                    pool_n;
		phase_cfg = '{
			'{{2'b00, MAP_DIRECT}, 3'd0, 3'd6}, '{{2'b00, MAP_FIFO}, 3'd0, 3'd6},
			'{{2'b00, MAP_DIRECT}, 3'd1, 3'd6}, '{{2'b00, MAP_FIFO}, 3'd1, 3'd6},
			'{{2'b00, MAP_DIRECT}, 3'd0, 3'd1}, '{{2'b00, MAP_FIFO}, 3'd1, 3'd1},
			'{{2'b00, MAP_FIFO}, 3'd0, 3'd3}, '{{2'b00, MAP_DIRECT}, 3'd1, 3'd2}};
		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_MAPPING, phase_cfg[p][0]);
			write_reg(CFG_SPLIT, phase_cfg[p][1]);
			write_reg(CFG_LINES, phase_cfg[p][2]);
			set_idling(p % 4);
			// a few tag groups so lines collide and repeat
			for (int t = 0; t < 4; t++) tag_base[t] = (TAG_W-6)'($urandom);
			pool_n = $urandom_range(2, 16);
			for (int k = 0; k < 16; k++)
				line_pool[k] = {tag_base[$urandom_range(0, 3)], 6'($urandom_range(0, 63))};
			for (int n = 0; n < 80; n++) begin
				if ($urandom_range(0, 99) < 10)
					addr = $urandom;
				else
					addr = {line_pool[$urandom_range(0, pool_n - 1)],
						6'($urandom_range(0, 63))};
				send_item(addr, 1'($urandom_range(0, 1)));
				// let the pipe run empty once per phase
				if (n == 40) wait_idle();
			end
			wait_idle();
		end
	endtask

	// main sequence
	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_MAPPING;
		cfg_data           <= '0;
		req_ch.valid       <= 1'b0;
		req_ch.address     <= '0;
		req_ch.access_kind <= 1'b0;
		map_mode  = MAP_DIRECT;
		split_on  = 1'b0;
		lines_lg  = LINES_LOG2_RESET;
		acc_count = '0;
		hit_count = '0;
		invalidate_lines();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_direct_mapped();
		test_fifo_split();
		test_config_edges();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0 && pending_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
